// ===== rtl/wav_header_parser_unit_assert.svh =====
// assertion macros used by the port checker
`ifndef WAV_HEADER_PARSER_UNIT_ASSERT_SVH
`define WAV_HEADER_PARSER_UNIT_ASSERT_SVH

// clocked check, switched off while reset is held
`define WAVHP_CHK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also runs through reset
`define WAVHP_CHK_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/wavhp_pkg.sv =====
// types, constants and microcode program of the wav header parser
package wavhp_pkg;

  localparam int BYTE_W = 8;
  localparam int CHAN_W = 16;
  localparam int RATE_W = 32;
  localparam int BITS_W = 16;
  localparam int BAUD_W = 16;
  localparam int FRAC_W = 16;
  localparam int SPB_W  = RATE_W + FRAC_W;
  localparam int CNT_W  = 3;
  localparam int TAG_W  = 32;

  localparam logic [BAUD_W-1:0] BAUD_RESET = 16'd4800;

  localparam logic [TAG_W-1:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [TAG_W-1:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [TAG_W-1:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [TAG_W-1:0] TAG_DATA = 32'h6461_7461;

  localparam logic [BITS_W-1:0] WIDTH_8  = 16'd8;
  localparam logic [BITS_W-1:0] WIDTH_16 = 16'd16;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_TAG   = 2'd1,
    ST_EARLY = 2'd2,
    ST_WIDTH = 2'd3
  } status_t;

  // program steps, one per header section
  typedef enum logic [3:0] {
    S_IDLE      = 4'd0,
    S_RIFF      = 4'd1,
    S_SIZE      = 4'd2,
    S_WAVE      = 4'd3,
    S_SCAN_FMT  = 4'd4,
    S_SKIP_A    = 4'd5,
    S_CHAN      = 4'd6,
    S_RATE      = 4'd7,
    S_SKIP_B    = 4'd8,
    S_BITS      = 4'd9,
    S_SCAN_DATA = 4'd10,
    S_DSIZE     = 4'd11
  } step_t;

  // what a step does once its byte count is reached or its tag is seen
  typedef enum logic [2:0] {
    OP_NOP,
    OP_COUNT,
    OP_CHECK,
    OP_SCAN,
    OP_FINISH,
    OP_CLEAR
  } op_t;

  typedef enum logic [1:0] {
    TSEL_RIFF,
    TSEL_WAVE,
    TSEL_FMT,
    TSEL_DATA
  } tag_sel_t;

  typedef enum logic [1:0] {
    CAP_NONE,
    CAP_CHAN,
    CAP_RATE,
    CAP_BITS
  } cap_t;

  // one control word of the program
  typedef struct packed {
    op_t              op;
    logic             shift;
    tag_sel_t         tag;
    cap_t             cap;
    logic [CNT_W-1:0] len;
    step_t            next;
  } ucode_t;

  // control from the sequencer to the datapath, valid for the accepted word
  typedef struct packed {
    logic    clear;
    logic    shift;
    cap_t    cap;
    logic [1:0] k;
    logic    emit;
    status_t status;
  } ctrl_t;

  // program store
  function automatic ucode_t wavhp_ucode(input step_t s);
    ucode_t uw;
    unique case (s)
      S_IDLE:      uw = '{OP_NOP,    1'b0, TSEL_RIFF, CAP_NONE, 3'd0, S_IDLE};
      S_RIFF:      uw = '{OP_CHECK,  1'b1, TSEL_RIFF, CAP_NONE, 3'd4, S_SIZE};
      S_SIZE:      uw = '{OP_COUNT,  1'b0, TSEL_RIFF, CAP_NONE, 3'd4, S_WAVE};
      S_WAVE:      uw = '{OP_CHECK,  1'b1, TSEL_WAVE, CAP_NONE, 3'd4, S_SCAN_FMT};
      S_SCAN_FMT:  uw = '{OP_SCAN,   1'b1, TSEL_FMT,  CAP_NONE, 3'd0, S_SKIP_A};
      S_SKIP_A:    uw = '{OP_COUNT,  1'b0, TSEL_FMT,  CAP_NONE, 3'd6, S_CHAN};
      S_CHAN:      uw = '{OP_COUNT,  1'b0, TSEL_FMT,  CAP_CHAN, 3'd2, S_RATE};
      S_RATE:      uw = '{OP_COUNT,  1'b0, TSEL_FMT,  CAP_RATE, 3'd4, S_SKIP_B};
      S_SKIP_B:    uw = '{OP_COUNT,  1'b0, TSEL_FMT,  CAP_NONE, 3'd6, S_BITS};
      S_BITS:      uw = '{OP_COUNT,  1'b0, TSEL_FMT,  CAP_BITS, 3'd2, S_SCAN_DATA};
      S_SCAN_DATA: uw = '{OP_SCAN,   1'b1, TSEL_DATA, CAP_NONE, 3'd0, S_DSIZE};
      S_DSIZE:     uw = '{OP_FINISH, 1'b0, TSEL_DATA, CAP_NONE, 3'd4, S_IDLE};
      default:     uw = '{OP_CLEAR,  1'b0, TSEL_RIFF, CAP_NONE, 3'd0, S_IDLE};
    endcase
    return uw;
  endfunction

  function automatic logic [TAG_W-1:0] tag_value(input tag_sel_t t);
    logic [TAG_W-1:0] v;
    unique case (t)
      TSEL_RIFF: v = TAG_RIFF;
      TSEL_WAVE: v = TAG_WAVE;
      TSEL_FMT:  v = TAG_FMT;
      TSEL_DATA: v = TAG_DATA;
      default:   v = TAG_RIFF;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/wav_header_parser_unit.sv =====
// top level of the wav header parser: datapath, result register and baud register
//
//  channel  | valid        | stall        | payload
//  ---------+--------------+--------------+-------------------------------------------
//  bytes in | byte_valid   | byte_stall   | data_byte, start_of_stream, end_of_stream
//  result   | result_valid | result_stall | status, channels, rate_hz,
//           |              |              | bits_per_sample, samples_per_bit
//  config   | cfg_wen      | (none)       | cfg_wdata (baud rate)
//
// One header byte per cycle while byte_stall is low; the microcode sequencer handles each byte combinationally.
// A good header then waits on the divider after its last size byte: the divider yields one
// quotient bit per cycle, and byte_stall stays high until the result is registered.
// rst is synchronous and clears the sequencer, divider, captured fields and result valid flag at once.
// byte_stall also rises while a finished result waits in a stalled result register.
module wav_header_parser_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         byte_valid,
  output logic                         byte_stall,
  input  logic [wavhp_pkg::BYTE_W-1:0] data_byte,
  input  logic                         start_of_stream,
  input  logic                         end_of_stream,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic [1:0]                   status,
  output logic [wavhp_pkg::CHAN_W-1:0] channels,
  output logic [wavhp_pkg::RATE_W-1:0] rate_hz,
  output logic [wavhp_pkg::BITS_W-1:0] bits_per_sample,
  output logic [wavhp_pkg::SPB_W-1:0]  samples_per_bit,
  input  logic                         cfg_wen,
  input  logic [wavhp_pkg::BAUD_W-1:0] cfg_wdata
);
  import wavhp_pkg::*;

  ctrl_t             ctrl;
  logic              accept;
  logic              div_busy;
  logic              div_done;
  logic [SPB_W-1:0]  div_quo;
  logic [BAUD_W-1:0] baud;
  logic [TAG_W-1:0]  win;
  logic [TAG_W-1:0]  win_cur;
  logic [TAG_W-1:0]  win_shift;
  logic [CHAN_W-1:0] chan;
  logic [CHAN_W-1:0] chan_cur;
  logic [CHAN_W-1:0] chan_next;
  logic [RATE_W-1:0] rate;
  logic [RATE_W-1:0] rate_cur;
  logic [RATE_W-1:0] rate_next;
  logic [BITS_W-1:0] width;
  logic [BITS_W-1:0] width_cur;
  logic [BITS_W-1:0] width_next;
  logic              width_ok;
  logic              div_start;

  // handshake
  assign byte_stall = div_busy || (result_valid && result_stall);
  assign accept     = byte_valid && !byte_stall;

  // window candidate after a restart clears the window
  assign win_cur   = start_of_stream ? '0 : win;
  assign win_shift = {win_cur[TAG_W-BYTE_W-1:0], data_byte};
  assign width_ok  = (width == WIDTH_8) || (width == WIDTH_16);
  assign div_start = ctrl.emit && (ctrl.status == ST_OK);

  wavhp_seq u_seq (
    .clk             (clk),
    .rst             (rst),
    .accept          (accept),
    .start_of_stream (start_of_stream),
    .end_of_stream   (end_of_stream),
    .window          (win_shift),
    .width_ok        (width_ok),
    .ctrl            (ctrl)
  );

  wavhp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .rate     (rate),
    .baud     (baud),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  // field capture, little-endian byte lanes
  always_comb begin
    chan_cur  = ctrl.clear ? '0 : chan;
    rate_cur  = ctrl.clear ? '0 : rate;
    width_cur = ctrl.clear ? '0 : width;
    chan_next  = chan_cur;
    rate_next  = rate_cur;
    width_next = width_cur;
    case (ctrl.cap)
      CAP_CHAN: begin
        if (ctrl.k == 2'd0) chan_next[7:0]  = data_byte;
        else                chan_next[15:8] = data_byte;
      end
      CAP_BITS: begin
        if (ctrl.k == 2'd0) width_next[7:0]  = data_byte;
        else                width_next[15:8] = data_byte;
      end
      CAP_RATE: begin
        case (ctrl.k)
          2'd0:    rate_next[7:0]   = data_byte;
          2'd1:    rate_next[15:8]  = data_byte;
          2'd2:    rate_next[23:16] = data_byte;
          default: rate_next[31:24] = data_byte;
        endcase
      end
      default: begin
        chan_next = chan_cur;
      end
    endcase
  end

  // tag window and captured fields
  always_ff @(posedge clk) begin
    if (rst) begin
      win   <= '0;
      chan  <= '0;
      rate  <= '0;
      width <= '0;
    end else begin
      if (ctrl.clear || ctrl.shift) begin
        win <= ctrl.shift ? win_shift : '0;
      end
      chan  <= chan_next;
      rate  <= rate_next;
      width <= width_next;
    end
  end

  // baud register
  always_ff @(posedge clk) begin
    if (rst) begin
      baud <= BAUD_RESET;
    end else if (cfg_wen) begin
      baud <= cfg_wdata;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (div_done) begin
      result_valid    <= 1'b1;
      status          <= ST_OK;
      channels        <= chan;
      rate_hz         <= rate;
      bits_per_sample <= width;
      samples_per_bit <= div_quo;
    end else if (ctrl.emit && (ctrl.status != ST_OK)) begin
      result_valid    <= 1'b1;
      status          <= ctrl.status;
      channels        <= chan_cur;
      rate_hz         <= rate_cur;
      bits_per_sample <= width_cur;
      samples_per_bit <= '0;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

endmodule

// ===== rtl/wavhp_seq.sv =====
// microcode sequencer: step counter, byte counter and jump logic
module wavhp_seq (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic                        start_of_stream,
  input  logic                        end_of_stream,
  input  logic [wavhp_pkg::TAG_W-1:0] window,
  input  logic                        width_ok,
  output wavhp_pkg::ctrl_t            ctrl
);
  import wavhp_pkg::*;

  step_t            step;
  step_t            step_next;
  step_t            cur_step;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic [CNT_W-1:0] cur_cnt;
  logic [CNT_W-1:0] cnt_inc;
  logic             cnt_done;
  logic             tag_hit;
  logic             active;
  ucode_t           uw;

  // fetch the control word and decide the jump
  always_comb begin
    cur_step = start_of_stream ? S_RIFF : step;
    cur_cnt  = start_of_stream ? '0 : cnt;
    uw       = wavhp_ucode(cur_step);
    active   = accept && (cur_step != S_IDLE);
    cnt_inc  = cur_cnt + 1'b1;
    cnt_done = (uw.len != '0) && (cnt_inc >= uw.len);
    tag_hit  = (window == tag_value(uw.tag));

    step_next   = cur_step;
    cnt_next    = cur_cnt;
    ctrl.clear  = accept && start_of_stream;
    ctrl.shift  = 1'b0;
    ctrl.cap    = CAP_NONE;
    ctrl.k      = cur_cnt[1:0];
    ctrl.emit   = 1'b0;
    ctrl.status = ST_OK;

    if (active) begin
      if (end_of_stream) begin
        ctrl.emit   = 1'b1;
        ctrl.status = ST_EARLY;
        step_next   = S_IDLE;
        cnt_next    = '0;
      end else begin
        ctrl.shift = uw.shift;
        ctrl.cap   = uw.cap;
        if (uw.len != '0) begin
          cnt_next = cnt_done ? '0 : cnt_inc;
        end
        unique case (uw.op)
          OP_CLEAR: begin
            ctrl.clear = 1'b1;
            step_next  = S_IDLE;
            cnt_next   = '0;
          end
          OP_SCAN: begin
            if (tag_hit) begin
              step_next = uw.next;
              cnt_next  = '0;
            end
          end
          OP_CHECK: begin
            if (cnt_done) begin
              if (!tag_hit) begin
                ctrl.emit   = 1'b1;
                ctrl.status = ST_TAG;
                step_next   = S_IDLE;
                cnt_next    = '0;
              end else begin
                step_next = uw.next;
              end
            end
          end
          OP_FINISH: begin
            if (cnt_done) begin
              ctrl.emit   = 1'b1;
              ctrl.status = width_ok ? ST_OK : ST_WIDTH;
              step_next   = S_IDLE;
              cnt_next    = '0;
            end
          end
          OP_COUNT: begin
            if (cnt_done) begin
              step_next = uw.next;
            end
          end
          default: begin
            step_next = cur_step;
          end
        endcase
      end
    end
  end

  // step and byte counters
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_IDLE;
      cnt  <= '0;
    end else if (accept) begin
      step <= step_next;
      cnt  <= cnt_next;
    end
  end

endmodule

// ===== rtl/wavhp_div.sv =====
// radix-2 restoring divider for the Q32.16 samples-per-bit value
module wavhp_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [wavhp_pkg::RATE_W-1:0] rate,
  input  logic [wavhp_pkg::BAUD_W-1:0] baud,
  output logic                         busy,
  output logic                         done,
  output logic [wavhp_pkg::SPB_W-1:0]  quotient
);
  import wavhp_pkg::*;

  localparam int ITER_W = $clog2(SPB_W);

  logic [ITER_W-1:0] iter;
  logic [BAUD_W-1:0] rem;
  logic [BAUD_W-1:0] divisor;
  logic [SPB_W-1:0]  quo;
  logic [BAUD_W:0]   rem_sh;
  logic [BAUD_W+1:0] diff;
  logic              ge;

  // one quotient bit per cycle; a zero divisor yields all ones
  always_comb begin
    rem_sh   = {rem, quo[SPB_W-1]};
    diff     = {1'b0, rem_sh} - {2'b00, divisor};
    ge       = !diff[BAUD_W+1];
    done     = busy && (iter == ITER_W'(SPB_W - 1));
    quotient = {quo[SPB_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      iter <= '0;
    end else if (start) begin
      busy    <= 1'b1;
      iter    <= '0;
      rem     <= '0;
      divisor <= baud;
      quo     <= {rate, {FRAC_W{1'b0}}};
    end else if (busy) begin
      rem  <= ge ? diff[BAUD_W-1:0] : rem_sh[BAUD_W-1:0];
      quo  <= quotient;
      iter <= iter + 1'b1;
      if (done) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/wavhp_checker.sv =====
// port checker for the wav header parser, bound to the top level
`include "wav_header_parser_unit_assert.svh"

module wavhp_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         byte_valid,
  input logic                         byte_stall,
  input logic                         result_valid,
  input logic                         result_stall,
  input logic [1:0]                   status,
  input logic [wavhp_pkg::BITS_W-1:0] bits_per_sample,
  input logic [wavhp_pkg::SPB_W-1:0]  samples_per_bit
);
  import wavhp_pkg::*;

  // result word holds while stalled
  `WAVHP_CHK(a_hold, result_valid && result_stall |=> result_valid && $stable(status) && $stable(samples_per_bit), "result changed in stall")

  // only a good header carries a ratio
  `WAVHP_CHK(a_spb_zero, result_valid && (status != ST_OK) |-> samples_per_bit == '0, "ratio set on failed header")

  // a good header has a supported sample width
  `WAVHP_CHK(a_width, result_valid && (status == ST_OK) |-> bits_per_sample == WIDTH_8 || bits_per_sample == WIDTH_16, "ok with bad width")

  // no byte word taken while a result word waits
  `WAVHP_CHK(a_in_block, byte_valid && result_valid && result_stall |-> byte_stall, "byte taken while result waits")

  // reset empties the result register
  `WAVHP_CHK_RST(a_rst, rst |=> !result_valid, "result valid after reset")

endmodule

bind wav_header_parser_unit wavhp_checker u_wavhp_checker (
  .clk             (clk),
  .rst             (rst),
  .byte_valid      (byte_valid),
  .byte_stall      (byte_stall),
  .result_valid    (result_valid),
  .result_stall    (result_stall),
  .status          (status),
  .bits_per_sample (bits_per_sample),
  .samples_per_bit (samples_per_bit)
);
